### sv/ntcfg_pkg.sv
// ntcfg_pkg: shared types, constants and the functions that build the
// conversion table for the NTC temperature reader with fault guard. No dependencies.

package ntcfg_pkg;

  // ADC code space
  localparam int ADC_BITS  = 12;
  localparam int TBL_SIZE  = 1 << ADC_BITS;
  localparam logic [ADC_BITS-1:0] CODE_MAX = ADC_BITS'(TBL_SIZE - 1);

  // Field widths
  localparam int TEMP_W    = 16;
  localparam int RISE_W    = 15;
  localparam int TIME_W    = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  // Fixed-point constants of the beta conversion
  localparam int          FRAC_BITS  = 24;
  localparam longint      LN2_Q30    = 64'd744261118;
  localparam longint      T25_CK     = 29815;      // 298.15 K in hundredths
  localparam longint      T0_Q6      = 174816;     // 273.15 K * 10 * 64
  localparam int          TBL_W      = TBL_SIZE * TEMP_W;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ADC_LOW    = 3'd0,
    CFG_ADC_HIGH   = 3'd1,
    CFG_TEMP_LOW   = 3'd2,
    CFG_TEMP_HIGH  = 3'd3,
    CFG_MAX_RISE   = 3'd4,
    CFG_RECOVERY   = 3'd5,
    CFG_ERROR_CODE = 3'd6
  } cfg_idx_e;

  // Configuration register set
  typedef struct packed {
    logic        [ADC_BITS-1:0] adc_low;
    logic        [ADC_BITS-1:0] adc_high;
    logic signed [TEMP_W-1:0]   temp_low;
    logic signed [TEMP_W-1:0]   temp_high;
    logic        [RISE_W-1:0]   max_rise;
    logic        [TIME_W-1:0]   recovery_ms;
    logic signed [TEMP_W-1:0]   error_code;
  } ntcfg_cfg_t;

  // Item after the table lookup stage
  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic                     window_bad;
    logic        [TIME_W-1:0] now_ms;
  } ntcfg_item_t;

  // log2 of v >= 1 in Q24: integer part from the top bit, fraction by squaring
  function automatic logic [63:0] ntcfg_log2_q24(input logic [63:0] v);
    int          top;
    logic [63:0] m;
    logic [63:0] frac;
    top  = 0;
    frac = '0;
    for (int k = 0; k < 64; k++) begin
      if (v[k]) top = k;
    end
    if (top >= 30) m = v >> (top - 30);
    else           m = v << (30 - top);
    for (int i = FRAC_BITS - 1; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        frac[i] = 1'b1;
        m       = m >> 1;
      end
    end
    return (64'(top) << FRAC_BITS) + frac;
  endfunction

  // Unsigned 64-bit quotient by shift and subtract
  function automatic logic [63:0] ntcfg_udiv64(input logic [63:0] num,
                                               input logic [63:0] dvs);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, dvs}) begin
        rem    = rem - {1'b0, dvs};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // One table entry: temperature in tenths for ADC code a
  function automatic logic [TEMP_W-1:0] ntcfg_convert(input longint a,
                                                      input longint beta,
                                                      input longint series,
                                                      input longint nominal);
    logic [63:0]        n;
    logic [63:0]        d;
    logic signed [63:0] ld;
    logic [63:0]        mag;
    logic signed [63:0] lnq;
    logic signed [63:0] den;
    logic [63:0]        num;
    logic [63:0]        q;
    logic signed [63:0] r;
    n   = 64'(series) * 64'(longint'(TBL_SIZE - 1) - a);
    d   = 64'(a) * 64'(nominal);
    ld  = $signed(ntcfg_log2_q24(n)) - $signed(ntcfg_log2_q24(d));
    mag = (ld < 0) ? 64'(-ld) : 64'(ld);
    lnq = $signed((mag * 64'(LN2_Q30)) >> 30);
    if (ld < 0) lnq = -lnq;
    den = 64'(100 * beta) * (64'sd1 <<< FRAC_BITS) + 64'(T25_CK) * lnq;
    if (den <= 0) return 16'sh7FFF;
    num = 64'(beta) * 64'(T25_CK) * (64'd1 << FRAC_BITS) * 64'd640;
    q   = ntcfg_udiv64(num, 64'(den));
    if (q > 64'h7FFF_FFFF * 64'd64) return 16'sh7FFF;
    r = $signed(q) - 64'(T0_Q6);
    r = (r >= 0) ? (r >>> 6) : -((-r) >>> 6);
    if (r > 32767)  r = 32767;
    if (r < -32768) r = -32768;
    return r[TEMP_W-1:0];
  endfunction

  // Whole table, entry a at bits [a*16 +: 16]; rail codes hold zero
  function automatic logic [TBL_W-1:0] ntcfg_build_table(input longint beta,
                                                         input longint series,
                                                         input longint nominal);
    logic [TBL_W-1:0] tbl;
    tbl = '0;
    for (int a = 1; a < TBL_SIZE - 1; a++) begin
      tbl[a*TEMP_W +: TEMP_W] = ntcfg_convert(longint'(a), beta, series, nominal);
    end
    return tbl;
  endfunction

endpackage

### sv/ntcfg_if.sv
// ntcfg_if: valid/ready channel interfaces for samples, results and
// configuration writes. Depends on ntcfg_pkg.

interface ntcfg_in_if import ntcfg_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] adc_sample;
  logic [TIME_W-1:0]   now_ms;
  modport source (output valid, adc_sample, now_ms, input ready);
  modport sink   (input valid, adc_sample, now_ms, output ready);
endinterface

interface ntcfg_out_if import ntcfg_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature;
  logic                     is_error;
  modport source (output valid, temperature, is_error, input ready);
  modport sink   (input valid, temperature, is_error, output ready);
endinterface

interface ntcfg_cfg_if import ntcfg_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### sv/ntc_temperature_with_fault_guard.sv
// Top level of the NTC temperature reader with fault guard.
// Depends on ntcfg_pkg, ntcfg_if, ntcfg_cfg_regs, ntcfg_rom and ntcfg_guard.

// One ADC sample with its millisecond timestamp enters per clock and one
// result leaves per clock while the sink is ready; each sample passes the
// registered table read and then the checks into the result register. The
// conversion table has one entry per ADC code and is computed from the beta
// parameters at elaboration, so no fill pass runs after reset. A stalled
// result holds its register while the lookup stage keeps one more sample;
// input ready drops only when both are full and the sink is not ready.
// Configuration writes are taken in any cycle but must only be made while
// no sample is in flight.

module ntc_temperature_with_fault_guard import ntcfg_pkg::*; #(
  parameter int BETA_KELVIN  = 3950,
  parameter int SERIES_OHMS  = 10000,
  parameter int NOMINAL_OHMS = 10000
) (
  input  logic         clk,
  input  logic         rst_n,
  ntcfg_in_if.sink     in_if,
  ntcfg_out_if.source  out_if,
  ntcfg_cfg_if.sink    cfg_if
);

  ntcfg_cfg_t               cfg;
  logic                     in_take;
  logic                     window_bad;
  logic                     s1_valid_r;
  logic                     s1_window_bad_r;
  logic [TIME_W-1:0]        s1_now_r;
  logic signed [TEMP_W-1:0] s1_temp;
  logic                     s1_take;
  ntcfg_item_t              s1_item;

  ntcfg_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg    (cfg)
  );

  // Accept when the lookup stage is empty or moving on
  assign in_if.ready = !s1_valid_r || s1_take;
  assign in_take     = in_if.valid && in_if.ready;

  // Reject codes outside the window and at either rail
  assign window_bad = (in_if.adc_sample < cfg.adc_low) ||
                      (in_if.adc_sample > cfg.adc_high) ||
                      (in_if.adc_sample == '0) ||
                      (in_if.adc_sample == CODE_MAX);

  ntcfg_rom #(
    .BETA_KELVIN  (BETA_KELVIN),
    .SERIES_OHMS  (SERIES_OHMS),
    .NOMINAL_OHMS (NOMINAL_OHMS)
  ) u_rom (
    .clk     (clk),
    .rd_en   (in_take),
    .rd_addr (in_if.adc_sample),
    .rd_data (s1_temp)
  );

  // Lookup stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_take) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Lookup stage payload alongside the table read
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_window_bad_r <= window_bad;
      s1_now_r        <= in_if.now_ms;
    end
  end

  assign s1_item.temp       = s1_temp;
  assign s1_item.window_bad = s1_window_bad_r;
  assign s1_item.now_ms     = s1_now_r;

  ntcfg_guard u_guard (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (s1_valid_r),
    .item       (s1_item),
    .take       (s1_take),
    .out_if     (out_if)
  );

endmodule

### sv/ntcfg_cfg_regs.sv
// ntcfg_cfg_regs: configuration register file written over the cfg channel.
// Depends on ntcfg_pkg and ntcfg_if.

module ntcfg_cfg_regs import ntcfg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  ntcfg_cfg_if.sink   cfg_if,
  output ntcfg_cfg_t  cfg
);

  ntcfg_cfg_t cfg_r;

  // Always take writes; unknown indexes are dropped
  assign cfg_if.ready = 1'b1;
  assign cfg          = cfg_r;

  // Update the addressed register on each write transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.adc_low     <= '0;
      cfg_r.adc_high    <= CODE_MAX;
      cfg_r.temp_low    <= -16'sd400;
      cfg_r.temp_high   <= 16'sd1250;
      cfg_r.max_rise    <= 15'd50;
      cfg_r.recovery_ms <= 32'd5000;
      cfg_r.error_code  <= -16'sd9990;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        CFG_ADC_LOW:    cfg_r.adc_low     <= cfg_if.data[ADC_BITS-1:0];
        CFG_ADC_HIGH:   cfg_r.adc_high    <= cfg_if.data[ADC_BITS-1:0];
        CFG_TEMP_LOW:   cfg_r.temp_low    <= cfg_if.data[TEMP_W-1:0];
        CFG_TEMP_HIGH:  cfg_r.temp_high   <= cfg_if.data[TEMP_W-1:0];
        CFG_MAX_RISE:   cfg_r.max_rise    <= cfg_if.data[RISE_W-1:0];
        CFG_RECOVERY:   cfg_r.recovery_ms <= cfg_if.data[TIME_W-1:0];
        CFG_ERROR_CODE: cfg_r.error_code  <= cfg_if.data[TEMP_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### sv/ntcfg_rom.sv
// ntcfg_rom: beta-equation conversion table, filled at elaboration, with a
// registered read port. Depends on ntcfg_pkg.

module ntcfg_rom import ntcfg_pkg::*; #(
  parameter int BETA_KELVIN  = 3950,
  parameter int SERIES_OHMS  = 10000,
  parameter int NOMINAL_OHMS = 10000
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [ADC_BITS-1:0]      rd_addr,
  output logic signed [TEMP_W-1:0] rd_data
);

  localparam logic [TBL_W-1:0] ROM_DATA =
    ntcfg_build_table(longint'(BETA_KELVIN), longint'(SERIES_OHMS),
                      longint'(NOMINAL_OHMS));

  logic signed [TEMP_W-1:0] rd_data_r;

  // Read one entry per enabled cycle, hold otherwise
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= ROM_DATA[{rd_addr, 4'b0000} +: TEMP_W];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### sv/ntcfg_guard.sv
// ntcfg_guard: validity checks, fault state and the result register.
// Depends on ntcfg_pkg and ntcfg_if.

module ntcfg_guard import ntcfg_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  ntcfg_cfg_t   cfg,
  input  logic         item_valid,
  input  ntcfg_item_t  item,
  output logic         take,
  ntcfg_out_if.source  out_if
);

  logic signed [TEMP_W-1:0] last_good_r, last_good_nxt;
  logic                     awaiting_r, awaiting_nxt;
  logic                     in_fault_r, in_fault_nxt;
  logic [TIME_W-1:0]        fault_since_r, fault_since_nxt;

  logic                     out_valid_r;
  logic signed [TEMP_W-1:0] out_temp_r, out_temp_nxt;
  logic                     out_err_r, out_err_nxt;

  logic signed [TEMP_W:0]   rise;
  logic [TIME_W-1:0]        elapsed;
  logic                     reading_ok;

  // Move an item into the result register when it is empty or being drained
  assign take = item_valid && (!out_valid_r || out_if.ready);

  // Range, sentinel and one-sided rise checks
  assign rise       = {item.temp[TEMP_W-1], item.temp} - {last_good_r[TEMP_W-1], last_good_r};
  assign elapsed    = item.now_ms - fault_since_r;
  assign reading_ok = (item.temp != cfg.error_code) &&
                      (item.temp >= cfg.temp_low) &&
                      (item.temp <= cfg.temp_high) &&
                      ((last_good_r <= 0) ||
                       (rise <= $signed({2'b00, cfg.max_rise})));

  // Decide the result and the next guard state
  always_comb begin
    last_good_nxt   = last_good_r;
    awaiting_nxt    = awaiting_r;
    in_fault_nxt    = in_fault_r;
    fault_since_nxt = fault_since_r;
    out_temp_nxt    = cfg.error_code;
    out_err_nxt     = 1'b1;
    if (item.window_bad) begin
      if (!in_fault_r) begin
        in_fault_nxt    = 1'b1;
        fault_since_nxt = item.now_ms;
      end
    end else if (awaiting_r) begin
      last_good_nxt = item.temp;
      awaiting_nxt  = 1'b0;
      in_fault_nxt  = 1'b0;
      out_temp_nxt  = item.temp;
      out_err_nxt   = 1'b0;
    end else if (in_fault_r) begin
      if (elapsed > cfg.recovery_ms) begin
        if (reading_ok) begin
          in_fault_nxt  = 1'b0;
          last_good_nxt = item.temp;
          out_temp_nxt  = item.temp;
          out_err_nxt   = 1'b0;
        end else begin
          fault_since_nxt = item.now_ms;
        end
      end
    end else if (!reading_ok) begin
      in_fault_nxt    = 1'b1;
      fault_since_nxt = item.now_ms;
    end else begin
      last_good_nxt = item.temp;
      out_temp_nxt  = item.temp;
      out_err_nxt   = 1'b0;
    end
  end

  // Guard state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_good_r   <= '0;
      awaiting_r    <= 1'b1;
      in_fault_r    <= 1'b0;
      fault_since_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (take) begin
        last_good_r   <= last_good_nxt;
        awaiting_r    <= awaiting_nxt;
        in_fault_r    <= in_fault_nxt;
        fault_since_r <= fault_since_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r   <= 1'b0;
      end
    end
  end

  // Result payload, held while the sink stalls
  always_ff @(posedge clk) begin
    if (take) begin
      out_temp_r <= out_temp_nxt;
      out_err_r  <= out_err_nxt;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.temperature = out_temp_r;
  assign out_if.is_error    = out_err_r;

`ifndef NO_ASSERTIONS
  // An error result always carries the sentinel
  a_err_sentinel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_err_r |-> out_temp_r == cfg.error_code)
    else $error("error result without sentinel value");

  // Fault state after each transaction matches the error flag it produced
  a_fault_tracks_err: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> in_fault_r == $past(out_err_nxt))
    else $error("fault state disagrees with last result");

  // A good result becomes the new reference value
  a_last_good: assert property (@(posedge clk) disable iff (!rst_n)
    take && !out_err_nxt |=> last_good_r == $past(item.temp))
    else $error("last good value not updated");

  // Once the first reading is in, the first-sample bypass never returns
  a_first_once: assert property (@(posedge clk) disable iff (!rst_n)
    !awaiting_r |=> !awaiting_r)
    else $error("first-sample flag set again");
`endif

endmodule
